@@ rtl/ffssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffssa_pkg
// Shared types and constants of the first-fit segment seat allocator:
// result status codes, configuration register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffssa_pkg;

  // field widths fixed by the interface
  localparam int STN_W  = 5;
  localparam int SEAT_W = 5;
  localparam int STS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  // result status codes
  localparam logic [STS_W-1:0] ST_BOOKED  = 2'd0;
  localparam logic [STS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEATS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATIONS = 2'd1;

  // reset values of the configuration registers
  localparam logic [CFG_DAT_W-1:0] SEATS_RST    = 5'd16;
  localparam logic [CFG_DAT_W-1:0] STATIONS_RST = 5'd16;

  // controller to datapath commands
  typedef struct packed {
    logic             load;        // latch request and check stations
    logic             scan_start;  // read first seat word
    logic             scan_next;   // step to next seat word
    logic             commit;      // write marked word back
    logic             emit;        // present result
    logic [STS_W-1:0] emit_status;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic invalid;   // request stations out of range
    logic no_seats;  // effective seat count is zero
    logic hit;       // current seat word is free over the mask
    logic last;      // current seat is the last one in use
  } ctrl_sts_t;

endpackage

@@ rtl/ffssa_dp.sv @@
// ----------------------------------------------------------------------------
// ffssa_dp
// Datapath of the seat allocator: configuration registers, request
// registers, segment mask, occupancy memory with per-seat valid bits,
// seat counter and result registers.
// ----------------------------------------------------------------------------
module ffssa_dp
  import ffssa_pkg::*;
#(
  parameter int SEATS    = 16,
  parameter int STATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // request
  input  logic [STN_W-1:0]     in_departure,
  input  logic [STN_W-1:0]     in_destination,
  // control
  input  ctrl_cmd_t            cmd,
  output ctrl_sts_t            sts,
  // result
  output logic                 out_valid,
  output logic [STS_W-1:0]     out_status,
  output logic [SEAT_W-1:0]    out_seat
);

  localparam int SEGW = STATIONS - 1;
  localparam int AW   = (SEATS > 1) ? $clog2(SEATS) : 1;
  localparam int CW   = (AW + 1 > SEAT_W) ? AW + 1 : SEAT_W;
  localparam int IW   = 7;  // holds station and segment numbers up to 127
  localparam int NW   = 9;  // holds seat counts up to 511

  // configuration registers
  logic [CFG_DAT_W-1:0] seats_r, stations_r;
  // request registers
  logic [SEGW-1:0]      mask_r, mask_nxt;
  logic                 inv_r, inv_nxt;
  // occupancy store
  logic [SEGW-1:0]      mem [SEATS];
  logic [SEATS-1:0]     vld_r;
  logic [SEGW-1:0]      rd_data_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_addr;
  logic [SEGW-1:0]      word;
  // seat counter
  logic [AW-1:0]        seat_r, seat_nxt;
  logic [CW-1:0]        seat_num;
  // effective counts
  logic [CFG_DAT_W-1:0] nseat, nstat;
  // result registers
  logic                 out_valid_r;
  logic [STS_W-1:0]     out_status_r;
  logic [SEAT_W-1:0]    out_seat_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seats_r    <= SEATS_RST;
      stations_r <= STATIONS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEATS:    seats_r    <= cfg_data;
        REG_STATIONS: stations_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective counts, capped at the built size
  always_comb begin
    nseat = ({{(NW-CFG_DAT_W){1'b0}}, seats_r} > NW'(SEATS))
            ? CFG_DAT_W'(SEATS) : seats_r;
    nstat = ({{(IW-CFG_DAT_W){1'b0}}, stations_r} > IW'(STATIONS))
            ? CFG_DAT_W'(STATIONS) : stations_r;
  end

  // station check and segment mask of the incoming request
  always_comb begin
    inv_nxt = (in_departure == '0) || (in_departure > nstat) ||
              (in_destination > nstat) || (in_destination <= in_departure);
    for (int i = 0; i < SEGW; i++) begin
      mask_nxt[i] = (IW'(i) + IW'(1) >= {{(IW-STN_W){1'b0}}, in_departure}) &&
                    (IW'(i) + IW'(2) <= {{(IW-STN_W){1'b0}}, in_destination});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r <= mask_nxt;
      inv_r  <= inv_nxt;
    end
  end

  // seat counter and read address
  always_comb begin
    seat_nxt = seat_r;
    if (cmd.scan_start) begin
      seat_nxt = '0;
    end else if (cmd.scan_next) begin
      seat_nxt = seat_r + AW'(1);
    end
    rd_addr = cmd.scan_start ? '0 : seat_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    seat_r <= seat_nxt;
  end

  // occupancy memory, registered read, write-back of the marked word
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.commit) begin
      mem[seat_r] <= word | mask_r;
    end
  end

  // valid bits: a seat never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (cmd.commit) begin
        vld_r[seat_r] <= 1'b1;
      end
    end
  end

  assign word = rd_vld_r ? rd_data_r : '0;

  // status towards the controller
  assign seat_num     = {{(CW-AW){1'b0}}, seat_r} + CW'(1);
  assign sts.invalid  = inv_r;
  assign sts.no_seats = (nseat == '0);
  assign sts.hit      = ((word & mask_r) == '0);
  assign sts.last     = (seat_num >= CW'(nseat));

  // result registers, strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_seat_r   <= (cmd.emit_status == ST_BOOKED) ? seat_num[SEAT_W-1:0] : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_seat   = out_seat_r;

endmodule

@@ rtl/ffssa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffssa_ctrl
// Controller of the seat allocator: takes a request, checks it, then walks
// the seats one word per cycle until a free one is found or the seats in
// use run out.
// ----------------------------------------------------------------------------
module ffssa_ctrl
  import ffssa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd,
  input  ctrl_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.invalid) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_INVALID;
          state_nxt       = S_IDLE;
        end else if (sts.no_seats) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.commit      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BOOKED;
          state_nxt       = S_IDLE;
        end else if (sts.last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/first_fit_segment_seat_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_seat_allocator
// First-fit seat allocation over station-to-station segments, with an
// occupancy word per seat that is cleared at reset.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result appears
// on out_status and out_seat for one cycle with out_valid high and must be
// captured then; the receiver cannot stall it. A request with invalid stations
// or with no seats in use ends without a scan; otherwise the seats in use are
// scanned in order until a seat is booked or all of them are found taken.
// The scan is paced by the occupancy memory, which gives one seat word per
// cycle through its single read port. busy falls in the cycle of the strobe, so
// the next request can be taken there. Configuration writes are always accepted
// and should be made only while busy is low. No clearing pass after reset.
// ----------------------------------------------------------------------------
module first_fit_segment_seat_allocator
  import ffssa_pkg::*;
#(
  parameter int SEATS    = 16,
  parameter int STATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request transaction
  input  logic                 start,
  output logic                 busy,
  input  logic [STN_W-1:0]     in_departure,
  input  logic [STN_W-1:0]     in_destination,
  // result transaction
  output logic                 out_valid,
  output logic [STS_W-1:0]     out_status,
  output logic [SEAT_W-1:0]    out_seat,
  // configuration transaction
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // controller
  ffssa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // datapath
  ffssa_dp #(
    .SEATS    (SEATS),
    .STATIONS (STATIONS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_departure   (in_departure),
    .in_destination (in_destination),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_seat       (out_seat)
  );

endmodule

@@ tb/first_fit_segment_seat_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_seat_allocator_test
// Self-checking bench for the first-fit seat allocator. Requests are driven
// through the start/busy handshake. A local copy of the per-seat segment map
// and of the two limit registers predicts status and seat for every accepted
// transaction. Each strobed result is checked against the oldest prediction.
// Directed tests cover route extremes, bad station pairs, register limits
// and seat exhaustion. Random traffic then runs with varied limits and
// sender gaps.
// ----------------------------------------------------------------------------
module first_fit_segment_seat_allocator_test;
  import ffssa_pkg::*;

  localparam int SEATS        = 16;
  localparam int STATIONS     = 16;
  localparam int LIMIT_CYCLES = 400_000;

  // indexes outside the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [SEAT_W-1:0] seat;
  } booking_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [STN_W-1:0] in_departure;
  logic [STN_W-1:0] in_destination;
  logic out_valid;
  logic [STS_W-1:0] out_status;
  logic [SEAT_W-1:0] out_seat;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // mirror of the allocator state
  logic [STATIONS-2:0] seat_segments [SEATS];
  logic [CFG_DAT_W-1:0] seat_limit;
  logic [CFG_DAT_W-1:0] station_limit;

  booking_t pending_bookings [$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int idle_pct       = 0;

  first_fit_segment_seat_allocator #(
    .SEATS   (SEATS),
    .STATIONS(STATIONS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_departure  (in_departure),
    .in_destination(in_destination),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_seat      (out_seat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // station count after capping at the route size
  function automatic int route_stations();
    return (station_limit > STATIONS) ? STATIONS : int'(station_limit);
  endfunction

  // first-fit booking over the mirrored segment map
  function automatic booking_t book_journey(logic [STN_W-1:0] dep, logic [STN_W-1:0] dst);
    int seats_eff;
    int stations_eff;
    logic [STATIONS-2:0] span;
    booking_t res;
    seats_eff    = (seat_limit > SEATS) ? SEATS : int'(seat_limit);
    stations_eff = route_stations();
    res.status   = ST_INVALID;
    res.seat     = '0;
    if (dep == 0 || dep > stations_eff || dst > stations_eff || dst <= dep) return res;
    span = '0;
    for (int s = dep; s < dst; s++) span[s-1] = 1'b1;
    res.status = ST_FULL;
    for (int k = 0; k < seats_eff; k++) begin
      if ((seat_segments[k] & span) == '0) begin
        seat_segments[k] |= span;
        res.status = ST_BOOKED;
        res.seat   = SEAT_W'(k + 1);
        break;
      end
    end
    return res;
  endfunction

  // one request transaction, start left high for a following request
  task automatic request_seat(input logic [STN_W-1:0] dep, input logic [STN_W-1:0] dst);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start          <= 1'b1;
    in_departure   <= dep;
    in_destination <= dst;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_bookings.insert(pending_bookings.size(), book_journey(dep, dst));
  endtask

  // stop requesting and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    while (pending_bookings.size() != 0) @(posedge clk);
    repeat (SEATS + 4) @(posedge clk);
  endtask

  // register write, only ever made with the allocator idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SEATS) seat_limit = data;
    else if (idx == REG_STATIONS) station_limit = data;
  endtask

  // reset limits, whole route and single segments at both ends
  task automatic test_default_route();
    request_seat(5'd1, 5'd16);
    request_seat(5'd1, 5'd2);
    request_seat(5'd15, 5'd16);
  endtask

  // zero departure, reversed or equal stations, stations past the route, also under a lowered station limit
  task automatic test_invalid_stations();
    request_seat(5'd0, 5'd5);
    request_seat(5'd0, 5'd0);
    request_seat(5'd5, 5'd5);
    request_seat(5'd9, 5'd3);
    request_seat(5'd17, 5'd20);
    request_seat(5'd3, 5'd17);
    request_seat(5'd31, 5'd31);
    request_seat(5'd16, 5'd16);
    write_register(REG_STATIONS, 5'd5);
    request_seat(5'd4, 5'd6);
    request_seat(5'd4, 5'd5);
  endtask

  // zero seats, too few stations, capped counts, writes to unused indexes
  task automatic test_register_extremes();
    write_register(REG_SEATS, 5'd0);
    request_seat(5'd2, 5'd3);
    write_register(REG_STATIONS, 5'd1);
    request_seat(5'd1, 5'd2);
    write_register(REG_STATIONS, 5'd0);
    request_seat(5'd1, 5'd2);
    write_register(REG_SEATS, 5'd31);
    write_register(REG_STATIONS, 5'd31);
    request_seat(5'd3, 5'd7);
    write_register(REG_SPARE_LO, 5'd1);
    write_register(REG_SPARE_HI, 5'd0);
    request_seat(5'd1, 5'd16);
  endtask

  // no seat free, then seats brought back into use keep their bookings
  task automatic test_seat_exhaustion();
    write_register(REG_SEATS, 5'd1);
    write_register(REG_STATIONS, 5'd16);
    request_seat(5'd1, 5'd16);
    write_register(REG_SEATS, 5'd2);
    request_seat(5'd2, 5'd15);
    request_seat(5'd2, 5'd15);
    write_register(REG_SEATS, 5'd3);
    request_seat(5'd2, 5'd15);
  endtask

  // chunks of mostly well-formed journeys under random limits
  task automatic test_random_traffic(input int gap_pct, input int seat_cap);
    int stn;
    int dep;
    int dst;
    int pick;
    idle_pct = gap_pct;
    for (int chunk = 0; chunk < 6; chunk++) begin
      write_register(REG_SEATS, ($urandom_range(9) == 0) ? 5'd0
                                                          : CFG_DAT_W'($urandom_range(1, seat_cap)));
      pick = $urandom_range(9);
      if (pick == 0)      write_register(REG_STATIONS, CFG_DAT_W'($urandom_range(0, 1)));
      else if (pick == 1) write_register(REG_STATIONS, CFG_DAT_W'($urandom_range(17, 31)));
      else                write_register(REG_STATIONS, CFG_DAT_W'($urandom_range(2, 16)));
      stn = route_stations();
      for (int n = 0; n < 61; n++) begin
        if (stn < 2 || $urandom_range(99) < 15) begin
          dep = $urandom_range(31);
          dst = $urandom_range(31);
        end else begin
          dep = $urandom_range(1, stn - 1);
          if ($urandom_range(1)) dst = $urandom_range(dep + 1, stn);
          else begin
            dst = dep + $urandom_range(1, 2);
            if (dst > stn) dst = stn;
          end
        end
        request_seat(STN_W'(dep), STN_W'(dst));
      end
    end
  endtask

  // result checker, the receiver cannot stall so every strobe is taken
  always @(posedge clk) begin : check_result
    booking_t want;
    if (rst_n && out_valid) begin
      if (pending_bookings.size() == 0) begin
        $error("unexpected result transaction: status %0d seat %0d", out_status, out_seat);
        mismatch_count++;
      end else begin
        want = pending_bookings.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_seat !== want.seat) begin
          $error("seat: expected %0d, actual %0d", want.seat, out_seat);
          mismatch_count++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_departure   <= '0;
    in_destination <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    for (int k = 0; k < SEATS; k++) seat_segments[k] = '0;
    seat_limit    = SEATS_RST;
    station_limit = STATIONS_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_route();
    test_invalid_stations();
    test_register_extremes();
    test_seat_exhaustion();
    test_random_traffic(25, 6);
    test_random_traffic(73, 11);
    test_random_traffic(0, 31);
    settle();

    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
